// ===== hdl/phs_pkg.sv =====
// Package with shared types, constants and a helper function of the power handshake sequencer.
`timescale 1ns / 1ps

package phs_pkg;

  localparam int unsigned DEBOUNCE_SAMPLES = 8;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [15:0] TIMEOUT_LIMIT_RST       = 16'd1000;
  localparam logic [15:0] HOLD_RESET_LIMIT_RST    = 16'd500;
  localparam logic [7:0]  NORMAL_BLINK_PERIOD_RST = 8'd50;
  localparam logic [7:0]  ERROR_BLINK_PERIOD_RST  = 8'd10;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    REG_TIMEOUT_LIMIT       = 2'd0,
    REG_HOLD_RESET_LIMIT    = 2'd1,
    REG_NORMAL_BLINK_PERIOD = 2'd2,
    REG_ERROR_BLINK_PERIOD  = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    CODE_OFF      = 3'd0,
    CODE_STARTREQ = 3'd1,
    CODE_STARTACK = 3'd2,
    CODE_ON       = 3'd3,
    CODE_SHUTREQ  = 3'd4,
    CODE_SHUTACK  = 3'd5,
    CODE_ERROR    = 3'd6
  } seq_code_e;

  typedef enum logic [6:0] {
    ST_OFF      = 7'b0000001,
    ST_STARTREQ = 7'b0000010,
    ST_STARTACK = 7'b0000100,
    ST_ON       = 7'b0001000,
    ST_SHUTREQ  = 7'b0010000,
    ST_SHUTACK  = 7'b0100000,
    ST_ERROR    = 7'b1000000
  } seq_state_e;

  typedef struct packed {
    logic [15:0] timeout_limit;
    logic [15:0] hold_reset_limit;
    logic [7:0]  normal_blink_period;
    logic [7:0]  error_blink_period;
  } cfg_t;

  function automatic seq_code_e state_code(seq_state_e st);
    seq_code_e code;
    case (st)
      ST_OFF:      code = CODE_OFF;
      ST_STARTREQ: code = CODE_STARTREQ;
      ST_STARTACK: code = CODE_STARTACK;
      ST_ON:       code = CODE_ON;
      ST_SHUTREQ:  code = CODE_SHUTREQ;
      ST_SHUTACK:  code = CODE_SHUTACK;
      ST_ERROR:    code = CODE_ERROR;
      default:     code = CODE_OFF;
    endcase
    return code;
  endfunction

endpackage

// ===== hdl/phs_regs.sv =====
// Configuration register file of the power handshake sequencer behind an APB-style port.
`timescale 1ns / 1ps

module phs_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [phs_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [phs_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [phs_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready,
  output phs_pkg::cfg_t                      cfg_o
);

  phs_pkg::cfg_t      cfg_q;
  phs_pkg::cfg_t      cfg_d;
  phs_pkg::reg_idx_e  idx;
  logic               wr_en;

  assign idx    = phs_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        phs_pkg::REG_TIMEOUT_LIMIT:       cfg_d.timeout_limit       = pwdata[15:0];
        phs_pkg::REG_HOLD_RESET_LIMIT:    cfg_d.hold_reset_limit    = pwdata[15:0];
        phs_pkg::REG_NORMAL_BLINK_PERIOD: cfg_d.normal_blink_period = pwdata[7:0];
        phs_pkg::REG_ERROR_BLINK_PERIOD:  cfg_d.error_blink_period  = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      phs_pkg::REG_TIMEOUT_LIMIT:       prdata = {16'd0, cfg_q.timeout_limit};
      phs_pkg::REG_HOLD_RESET_LIMIT:    prdata = {16'd0, cfg_q.hold_reset_limit};
      phs_pkg::REG_NORMAL_BLINK_PERIOD: prdata = {24'd0, cfg_q.normal_blink_period};
      phs_pkg::REG_ERROR_BLINK_PERIOD:  prdata = {24'd0, cfg_q.error_blink_period};
      default:                          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_limit       <= phs_pkg::TIMEOUT_LIMIT_RST;
      cfg_q.hold_reset_limit    <= phs_pkg::HOLD_RESET_LIMIT_RST;
      cfg_q.normal_blink_period <= phs_pkg::NORMAL_BLINK_PERIOD_RST;
      cfg_q.error_blink_period  <= phs_pkg::ERROR_BLINK_PERIOD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hdl/power_handshake_sequencer.sv =====
// Top level of the power handshake sequencer: tick stream in, registered pin results out.
`timescale 1ns / 1ps

// Each request on the input stream is one timer tick carrying the switch, acknowledge and
// shutdown-request pin samples, and it produces exactly one result with the power, LED and
// request pin levels and the sequencer state after that tick. One request is taken every
// clock cycle unless the result stream stalls; a taken request is held in an input register,
// and the whole state update is done in one pass from there into the result register. A
// stalled result holds the next tick in the input register, and the input stream then stops
// until the result is taken. The user must write configuration through the APB-style port
// only while no tick is in flight; the block itself does not enforce this.
module power_handshake_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [0] switch_level, [1] host_ack, [2] host_shutdown_req, [7:3] zero
  input  logic [7:0]                     s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] power_on, [1] led_on, [2] request_out, [5:3] seq_state, [7:6] zero
  output logic [7:0]                     m_axis_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [phs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [phs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [phs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int unsigned DbW = phs_pkg::DEBOUNCE_SAMPLES;

  phs_pkg::cfg_t cfg;

  logic       in_vld_q;
  logic [2:0] in_q;
  logic       out_vld_q;
  logic [7:0] out_q;
  logic       adv;

  logic [DbW-1:0]       db_q, db_d;
  logic                 closed_q, closed_d;
  logic                 prev_q;
  phs_pkg::seq_state_e  st_q, st_d, st_sel;
  logic [15:0]          stay_q, stay_d;
  logic [15:0]          hold_q, hold_d;
  logic [7:0]           blink_q, blink_d, blink_inc, period;
  logic                 err_sel_q, err_sel_d;
  logic                 pwr_q, pwr_d, led_q, led_d, req_q, req_d;
  logic                 pressed, timed_out;
  logic                 lvl, ack, shut;

  phs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  assign lvl  = in_q[0];
  assign ack  = in_q[1];
  assign shut = in_q[2];

  always_comb begin
    db_d = {db_q[DbW-2:0], lvl};
    if (db_d == '0) begin
      closed_d = 1'b1;
    end else if (db_d == '1) begin
      closed_d = 1'b0;
    end else begin
      closed_d = closed_q;
    end

    pressed   = closed_d && !prev_q;
    timed_out = stay_q > cfg.timeout_limit;

    st_sel = st_q;
    case (st_q)
      phs_pkg::ST_OFF: begin
        if (pressed) st_sel = phs_pkg::ST_STARTREQ;
      end
      phs_pkg::ST_STARTREQ: begin
        if (timed_out) st_sel = phs_pkg::ST_ERROR;
        else if (ack) st_sel = phs_pkg::ST_STARTACK;
      end
      phs_pkg::ST_STARTACK: begin
        if (timed_out) st_sel = phs_pkg::ST_ERROR;
        else if (!ack) st_sel = phs_pkg::ST_ON;
      end
      phs_pkg::ST_ON: begin
        if (pressed || shut) st_sel = phs_pkg::ST_SHUTREQ;
      end
      phs_pkg::ST_SHUTREQ: begin
        if (timed_out) st_sel = phs_pkg::ST_ERROR;
        else if (ack) st_sel = phs_pkg::ST_SHUTACK;
      end
      phs_pkg::ST_SHUTACK: begin
        if (timed_out) st_sel = phs_pkg::ST_ERROR;
        else if (!ack) st_sel = phs_pkg::ST_OFF;
      end
      default: ;
    endcase

    if (st_sel != st_q) begin
      stay_d = '0;
    end else if (stay_q != phs_pkg::COUNT_MAX) begin
      stay_d = stay_q + 16'd1;
    end else begin
      stay_d = stay_q;
    end

    if (closed_d && prev_q) begin
      hold_d = (hold_q != phs_pkg::COUNT_MAX) ? hold_q + 16'd1 : hold_q;
    end else begin
      hold_d = '0;
    end

    st_d = (hold_d > cfg.hold_reset_limit) ? phs_pkg::ST_OFF : st_sel;

    period    = err_sel_q ? cfg.error_blink_period : cfg.normal_blink_period;
    blink_inc = blink_q + 8'd1;
    pwr_d     = pwr_q;
    req_d     = req_q;
    err_sel_d = err_sel_q;
    if (blink_inc > period) begin
      led_d   = !led_q;
      blink_d = '0;
    end else begin
      led_d   = led_q;
      blink_d = blink_inc;
    end

    case (st_d)
      phs_pkg::ST_OFF: begin
        err_sel_d = 1'b0;
        led_d     = 1'b0;
        pwr_d     = 1'b0;
      end
      phs_pkg::ST_STARTREQ: begin
        pwr_d = 1'b1;
        req_d = 1'b1;
      end
      phs_pkg::ST_STARTACK: req_d = 1'b0;
      phs_pkg::ST_ON:       led_d = 1'b1;
      phs_pkg::ST_SHUTREQ:  req_d = 1'b1;
      phs_pkg::ST_SHUTACK:  req_d = 1'b0;
      phs_pkg::ST_ERROR:    err_sel_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      db_q      <= '1;
      closed_q  <= 1'b0;
      prev_q    <= 1'b0;
      st_q      <= phs_pkg::ST_OFF;
      stay_q    <= '0;
      hold_q    <= '0;
      blink_q   <= '0;
      err_sel_q <= 1'b0;
      pwr_q     <= 1'b0;
      led_q     <= 1'b0;
      req_q     <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
        db_q      <= db_d;
        closed_q  <= closed_d;
        prev_q    <= closed_d;
        st_q      <= st_d;
        stay_q    <= stay_d;
        hold_q    <= hold_d;
        blink_q   <= blink_d;
        err_sel_q <= err_sel_d;
        pwr_q     <= pwr_d;
        led_q     <= led_d;
        req_q     <= req_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= s_axis_tdata[2:0];
    end
    if (adv) begin
      out_q <= {2'b00, phs_pkg::state_code(st_d), req_d, led_d, pwr_d};
    end
  end

endmodule

// ===== hdl/phs_checker.sv =====
// Port-level checker of the power handshake sequencer and its bind to the top level.
`timescale 1ns / 1ps

module phs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  logic [2:0] code;
  logic       pwr, led, req;

  assign code = m_axis_tdata[5:3];
  assign pwr  = m_axis_tdata[0];
  assign led  = m_axis_tdata[1];
  assign req  = m_axis_tdata[2];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("A stalled result changed or vanished.");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> code != 3'd7)
    else $error("The result carries the unused state code.");

  a_off_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && code == phs_pkg::CODE_OFF |-> !pwr && !led)
    else $error("Power or LED is on in the off state.");

  a_startreq_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && code == phs_pkg::CODE_STARTREQ |-> pwr && req)
    else $error("Start request state without power and request.");

  a_on_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && code == phs_pkg::CODE_ON |-> pwr && led && !req)
    else $error("On state with wrong pin levels.");

endmodule

bind power_handshake_sequencer phs_checker u_phs_checker (.*);
